FILE: sv/plen_pkg.sv
// ----------------------------------------------------------------------------
// plen_pkg: shared types and constants for the polyline length accumulator
// Request structs, field widths and square root unit sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package plen_pkg;

	localparam int COORD_W = 16;
	localparam int LEN_W   = 40;
	localparam int CNT_W   = 16;
	localparam int MAG_W   = 16;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int RAD_W   = SQ_W + 1;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int SQ_ITER = (RAD_W + 2) / 2;
	localparam int WORK_W  = 2 * SQ_ITER;
	localparam int ITER_W  = $clog2(SQ_ITER);

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic                      first;
	} vtx_req_t;

	typedef struct packed {
		logic [LEN_W-1:0] total_length;
		logic [CNT_W-1:0] vertex_count;
	} len_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

`default_nettype wire

FILE: sv/plen_sqrt.sv
// ----------------------------------------------------------------------------
// plen_sqrt: iterative integer square root
// Produces floor(sqrt(radicand)) one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plen_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [plen_pkg::RAD_W-1:0]    radicand,
	output logic      [plen_pkg::ROOT_W-1:0]   root,
	output plen_pkg::sqrt_stat_t               stat
);
	import plen_pkg::*;

	logic [WORK_W-1:0] rem_q;
	logic [WORK_W-1:0] res_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORK_W-1:0] sbit;
	logic [WORK_W-1:0] trial;
	logic              ge;

	always_comb begin
		sbit  = WORK_W'(1) << {cnt_q, 1'b0};
		trial = res_q + sbit;
		ge    = rem_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(SQ_ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WORK_W'(radicand);
			res_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + sbit;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign root        = res_q[ROOT_W-1:0];
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;

endmodule

`default_nettype wire

FILE: sv/polyline_length_accumulator.sv
// ----------------------------------------------------------------------------
// polyline_length_accumulator: running Euclidean length of a polyline
// Squares the vertex deltas on one shared multiplier, takes the integer
// square root iteratively and adds it to a saturating unsigned Q40.0 sum.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   vtx      in         vtx_valid/vtx_stall   vtx_req_t (x, y, first)
//   res      out        res_valid/res_stall   len_req_t (length, count)
//
// A vertex that starts a polyline goes from idle straight to the output.
// Any other vertex goes through two multiplier passes, one load of the
// square root unit, 17 root iterations at one bit per cycle, the sum, and
// the output register.
// A new vertex is taken only while the sequencer is idle.
// A held result stalls the sequencer only when the next result is ready.
// Reset clears the previous vertex, the count and the sum to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_length_accumulator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               vtx_valid,
	output logic                    vtx_stall,
	input  wire plen_pkg::vtx_req_t vtx,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output plen_pkg::len_req_t      res
);
	import plen_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MULX = 6'b000010,
		S_MULY = 6'b000100,
		S_GO   = 6'b001000,
		S_ROOT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                     state_q;
	logic signed [COORD_W-1:0]  prev_x_q;
	logic signed [COORD_W-1:0]  prev_y_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [LEN_W-1:0]           len_q;
	logic [MAG_W-1:0]           ax_q;
	logic [MAG_W-1:0]           ay_q;
	logic [SQ_W-1:0]            sqx_q;
	logic [SQ_W-1:0]            sqy_q;
	logic                       res_valid_q;
	len_req_t                   res_q;

	logic                       accept;
	logic                       start_poly;
	logic signed [COORD_W:0]    dx;
	logic signed [COORD_W:0]    dy;
	logic [COORD_W:0]           ndx;
	logic [COORD_W:0]           ndy;
	logic [MAG_W-1:0]           mul_a;
	logic [SQ_W-1:0]            prod;
	logic [RAD_W-1:0]           radicand;
	logic [ROOT_W-1:0]          root;
	sqrt_stat_t                 sq_stat;
	logic [LEN_W:0]             len_sum;
	logic                       out_free;

	assign vtx_stall  = (state_q != S_IDLE);
	assign accept     = vtx_valid && !vtx_stall;
	assign start_poly = vtx.first || (cnt_q == '0);
	assign out_free   = !res_valid_q || !res_stall;

	always_comb begin
		dx       = (COORD_W+1)'(vtx.x_coord) - (COORD_W+1)'(prev_x_q);
		dy       = (COORD_W+1)'(vtx.y_coord) - (COORD_W+1)'(prev_y_q);
		ndx      = -dx;
		ndy      = -dy;
		mul_a    = (state_q == S_MULX) ? ax_q : ay_q;
		prod     = mul_a * mul_a;
		radicand = RAD_W'(sqx_q) + RAD_W'(sqy_q);
		len_sum  = {1'b0, len_q} + (LEN_W+1)'(root);
	end

	plen_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_GO),
		.radicand (radicand),
		.root     (root),
		.stat     (sq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_OUT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_x_q <= vtx.x_coord;
						prev_y_q <= vtx.y_coord;
						if (start_poly) begin
							len_q   <= '0;
							cnt_q   <= CNT_W'(1);
							state_q <= S_OUT;
						end else begin
							state_q <= S_MULX;
						end
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_GO;
				S_GO:   state_q <= S_ROOT;
				S_ROOT: begin
					if (sq_stat.done) begin
						len_q   <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q <= dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
			ay_q <= dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
		end
		if (state_q == S_MULX) begin
			sqx_q <= prod;
		end
		if (state_q == S_MULY) begin
			sqy_q <= prod;
		end
		if (state_q == S_OUT && out_free) begin
			res_q.total_length <= len_q;
			res_q.vertex_count <= cnt_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: sv/plen_checker.sv
// ----------------------------------------------------------------------------
// plen_checker: port-level checks for the polyline length accumulator
// Watches both channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plen_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               vtx_valid,
	input  wire logic               vtx_stall,
	input  wire plen_pkg::vtx_req_t vtx,
	input  wire logic               res_valid,
	input  wire logic               res_stall,
	input  wire plen_pkg::len_req_t res
);
	import plen_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result request changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall |=> vtx_stall)
		else $error("vertex request taken while previous one still in work");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.vertex_count != '0)
		else $error("result request with zero vertex count");

	a_start_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.vertex_count == CNT_W'(1) |-> res.total_length == '0)
		else $error("single-vertex polyline with nonzero length");

endmodule

bind polyline_length_accumulator plen_checker u_plen_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the polyline length accumulator
// Vertices go in from a queue through a bursty driver, and a stalling monitor
// compares every running length and vertex count with an in-bench tracker.
// The run covers directed extremes, random polylines under several idling
// mixes, and one longer polyline sent at full rate.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import plen_pkg::*;

	localparam longint CYCLE_LIMIT = 1_000_000;
	localparam int     TAIL_CYCLES = 40;
	localparam int     LONG_RUN    = 100;

	typedef struct {
		vtx_req_t v;
		bit       drain;
	} pending_vtx_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     vtx_valid = 1'b0;
	logic     vtx_stall;
	vtx_req_t vtx       = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	len_req_t res;

	pending_vtx_t vertex_queue[$];
	len_req_t     expected_len[$];

	logic signed [COORD_W-1:0] path_prev_x = '0;
	logic signed [COORD_W-1:0] path_prev_y = '0;
	logic [CNT_W-1:0]          path_count  = '0;
	logic [LEN_W-1:0]          path_sum    = '0;

	bit     idle_on    = 1'b0;
	int     stall_pct  = 0;
	int     burst_left = 0;
	int     gap_left   = 0;
	int     stall_hold = 0;
	longint cycles     = 0;
	int     sent       = 0;
	int     checked    = 0;
	int     mismatches = 0;
	int     polylines  = 0;
	int     max_count  = 0;

	logic signed [COORD_W-1:0] gen_x = '0;
	logic signed [COORD_W-1:0] gen_y = '0;

	polyline_length_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned floor_root(longint unsigned sq);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int i = 17; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= sq)
				root = trial;
		end
		return root;
	endfunction

	function automatic len_req_t advance_polyline(vtx_req_t v);
		int              dx;
		int              dy;
		longint unsigned sq;
		logic [LEN_W:0]  acc;
		len_req_t        r;
		if (v.first || path_count == 0) begin
			path_sum   = '0;
			path_count = CNT_W'(1);
			polylines++;
		end else begin
			dx  = int'(v.x_coord) - int'(path_prev_x);
			dy  = int'(v.y_coord) - int'(path_prev_y);
			sq  = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
			acc = {1'b0, path_sum} + (LEN_W + 1)'(floor_root(sq));
			path_sum = (acc > {1'b0, LEN_MAX}) ? LEN_MAX : acc[LEN_W-1:0];
			if (path_count != CNT_MAX)
				path_count++;
		end
		path_prev_x = v.x_coord;
		path_prev_y = v.y_coord;
		if (int'(path_count) > max_count)
			max_count = int'(path_count);
		r.total_length = path_sum;
		r.vertex_count = path_count;
		return r;
	endfunction

	task automatic add_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input bit first, input bit drain);
		pending_vtx_t p;
		p.v.x_coord = x;
		p.v.y_coord = y;
		p.v.first   = first;
		p.drain     = drain;
		vertex_queue.push_back(p);
		gen_x = x;
		gen_y = y;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] last, int mode);
		case (mode)
			0: return COORD_W'($urandom);
			1: return last + COORD_W'($urandom_range(0, 1024)) - COORD_W'(512);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			default: return last;
		endcase
	endfunction

	task automatic queue_polyline(input int n, input bit drain);
		int mode;
		mode = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				mode = $urandom_range(0, 3);
			add_vertex(pick_coord(gen_x, mode), pick_coord(gen_y, mode), i == 0,
				drain && i == 0);
		end
	endtask

	task automatic queue_random(input int total);
		int n;
		int done_items;
		done_items = 0;
		while (done_items < total) begin
			if ($urandom_range(0, 9) == 0) begin
				add_vertex(COORD_W'($urandom), COORD_W'($urandom),
					1'($urandom_range(0, 1)), 0);
				done_items++;
			end else begin
				n = $urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
				queue_polyline(n, $urandom_range(0, 14) == 0);
				done_items += n;
			end
		end
	endtask

	task automatic wait_drained();
		while (vertex_queue.size() != 0 || expected_len.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result(input len_req_t got);
		len_req_t want;
		if (expected_len.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing pending: length %0d count %0d",
					$realtime, got.total_length, got.vertex_count);
		end else begin
			want = expected_len.pop_front();
			checked++;
			if (got.total_length !== want.total_length
					|| got.vertex_count !== want.vertex_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d: length %0d (want %0d), count %0d (want %0d)",
						$realtime, checked, got.total_length, want.total_length,
						got.vertex_count, want.vertex_count);
			end
		end
	endtask

	always @(posedge clk) begin
		bit send;
		send = 1'b0;
		if (arst_n) begin
			if (vtx_valid && !vtx_stall) begin
				expected_len.push_back(advance_polyline(vtx));
				void'(vertex_queue.pop_front());
				sent++;
				if (idle_on) begin
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40)
							: $urandom_range(0, 6);
					end
				end
			end
			if (vtx_valid && vtx_stall) begin
				send = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (vertex_queue.size() != 0
					&& !(vertex_queue[0].drain && expected_len.size() != 0)) begin
				send = 1'b1;
				vtx <= vertex_queue[0].v;
			end
			vtx_valid <= send;
		end
	end

	always @(posedge clk) begin
		bit s;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending.",
				cycles, expected_len.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			if (arst_n && res_valid && !res_stall)
				check_result(res);
			s = 1'b0;
			if (stall_hold > 0) begin
				stall_hold--;
				s = 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				s = 1'b1;
				if ($urandom_range(0, 49) == 0)
					stall_hold = $urandom_range(5, 60);
			end
			res_stall <= s;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on   = 1'b1;
		stall_pct = 20;
		add_vertex(16'sd100, -16'sd200, 0, 0);
		add_vertex(16'h7fff, 16'h7fff, 0, 0);
		add_vertex(16'h8000, 16'h8000, 0, 0);
		add_vertex(16'h7fff, 16'h8000, 0, 0);
		add_vertex(16'h8000, 16'h7fff, 0, 0);
		add_vertex(16'h0000, 16'h0000, 1, 0);
		add_vertex(16'h0000, 16'h0000, 0, 0);
		add_vertex(16'h0100, 16'h0000, 0, 0);
		add_vertex(16'h0100, 16'h0100, 0, 0);
		add_vertex(16'h0000, 16'h0000, 0, 0);
		add_vertex(16'haaaa, 16'h5555, 1, 0);
		add_vertex(16'h5555, 16'haaaa, 1, 0);
		add_vertex(16'haaaa, 16'h5555, 0, 0);
		add_vertex(16'hffff, 16'h0001, 0, 0);
		add_vertex(16'h0001, 16'hffff, 0, 1);
		add_vertex(16'h8000, 16'h7fff, 0, 0);
		add_vertex(16'h0003, 16'h0004, 1, 0);
		add_vertex(16'h0000, 16'h0000, 0, 0);
		wait_drained();

		queue_random(300);
		wait_drained();

		idle_on   = 1'b0;
		gap_left  = 0;
		stall_pct = 0;
		queue_random(150);
		wait_drained();

		idle_on   = 1'b1;
		stall_pct = 60;
		queue_random(100);
		wait_drained();

		idle_on   = 1'b0;
		gap_left  = 0;
		stall_pct = 0;
		for (int i = 0; i < LONG_RUN; i++)
			add_vertex(COORD_W'($urandom), COORD_W'($urandom), i == 0, 0);
		stall_pct = 30;
		add_vertex(16'h1234, 16'h4321, 0, 1);
		add_vertex(16'h0000, 16'h0000, 1, 0);
		add_vertex(16'h7fff, 16'h7fff, 0, 0);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d vertices over %0d polylines in %0d cycles.",
			checked, sent, polylines, cycles);
		$display("Longest polyline count reached %0d; %0d mismatches found.",
			max_count, mismatches);
		if (mismatches == 0 && expected_len.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: polyline_length_accumulator.f
sv/plen_pkg.sv
sv/plen_sqrt.sv
sv/polyline_length_accumulator.sv
sv/plen_checker.sv
tb/testbench.sv
